// File: hdl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg
// shared types, sizes and helpers for the tile accumulator
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int TILE_ROWS   = 4;
    localparam int TILE_COLS   = 8;
    localparam int NUM_ACC     = TILE_ROWS * TILE_COLS;
    localparam int IDX_W       = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;
    localparam int LANE_W      = 16;
    localparam int PROD_W      = 2 * LANE_W;
    localparam int ACC_W       = 48;
    localparam int WORD_W      = 64;
    localparam int ROW_W       = 2;
    localparam int COL_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [LANE_W-1:0] lane_t;

    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] b_row_high;
        logic [WORD_W-1:0] b_row_low;
        logic [WORD_W-1:0] a_column;
    } step_t;

    function automatic lane_t get_lane(input logic [WORD_W-1:0] word, input logic [1:0] sel);
        lane_t v;
        v = lane_t'(word >> (LANE_W * sel));
        return v;
    endfunction

endpackage

// File: hdl/matmul_tile_accumulator_unit.sv
// ----------------------------------------------------------------------------
// matmul_tile_accumulator_unit
// 4x8 outer-product accumulator for one tile of a fixed-point matrix product
// ----------------------------------------------------------------------------
// one inner-dimension step is taken per clock while the input queue has room
// and no closing step is held back; each step feeds 32 parallel 16x16
// multipliers, registered in prod_reg, then 32 48-bit adders into acc_reg.
// a step marked last also copies the finished sums into a snapshot bank,
// which is sent out one element per word in row-major order, 32 words per
// tile. the next tile accumulates while that happens, but its own last step
// waits until the bank has drained.
module matmul_tile_accumulator_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // a_column, b_row_low, b_row_high
    input  logic         s_axis_tlast,  // last_step
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,  // tile_row, tile_col, dot_value, zero pad
    output logic         m_axis_tlast   // last_result
);

    mta_pkg::step_t                   in_item, q_item;
    logic                             q_valid, q_ready;
    logic                             bank_busy, snap_valid;
    mta_pkg::acc_t                    snap_data [mta_pkg::NUM_ACC];
    logic [mta_pkg::ROW_W-1:0]        out_row;
    logic [mta_pkg::COL_W-1:0]        out_col;
    mta_pkg::acc_t                    out_value;

    assign in_item.a_column   = s_axis_tdata[63:0];
    assign in_item.b_row_low  = s_axis_tdata[127:64];
    assign in_item.b_row_high = s_axis_tdata[191:128];
    assign in_item.last       = s_axis_tlast;

    mta_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    mta_mac_array u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .bank_busy  (bank_busy),
        .snap_valid (snap_valid),
        .snap_data  (snap_data)
    );

    mta_drain u_drain
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_data  (snap_data),
        .busy       (bank_busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_value, out_col, out_row};

endmodule

// File: hdl/mta_front.sv
// ----------------------------------------------------------------------------
// mta_front
// input side: takes step words and holds them in a short queue
// ----------------------------------------------------------------------------
module mta_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mta_pkg::step_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output mta_pkg::step_t out_item
);

    mta_pkg::step_t                  queue_mem [mta_pkg::QUEUE_DEPTH];
    logic [mta_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mta_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mta_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                            push, pop;

    assign in_ready  = (count_reg != mta_pkg::CNT_W'(mta_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = queue_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mta_pkg::PTR_W'(mta_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mta_pkg::PTR_W'(mta_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mta_pkg::CNT_W'(mta_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hdl/mta_mac_array.sv
// ----------------------------------------------------------------------------
// mta_mac_array
// back side: multiplies one step's operands and updates all accumulators
// ----------------------------------------------------------------------------
module mta_mac_array
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mta_pkg::step_t     in_item,
    input  logic               bank_busy,
    output logic               snap_valid,
    output mta_pkg::acc_t      snap_data [mta_pkg::NUM_ACC]
);

    mta_pkg::prod_t prod_reg [mta_pkg::NUM_ACC];
    mta_pkg::acc_t  acc_reg  [mta_pkg::NUM_ACC];
    mta_pkg::acc_t  acc_next [mta_pkg::NUM_ACC];
    logic           s1_valid_reg, s1_last_reg, s1_start_reg;
    logic           start_reg;
    logic           pop;

    // a closing step needs the snapshot bank free when it lands
    assign in_ready = !in_item.last || (!bank_busy && !(s1_valid_reg && s1_last_reg));
    assign pop      = in_valid && in_ready;

    for (genvar i = 0; i < mta_pkg::NUM_ACC; i++)
    begin : g_mac
        localparam int ROW = i / mta_pkg::TILE_COLS;
        localparam int COL = i % mta_pkg::TILE_COLS;

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                prod_reg[i] <= mta_pkg::get_lane(in_item.a_column, 2'(ROW)) *
                               mta_pkg::get_lane((COL < 4) ? in_item.b_row_low
                                                           : in_item.b_row_high,
                                                 2'(COL % 4));
            end
        end

        always_comb
        begin
            if (s1_start_reg)
            begin
                acc_next[i] = mta_pkg::ACC_W'(prod_reg[i]);
            end
            else
            begin
                acc_next[i] = acc_reg[i] + mta_pkg::ACC_W'(prod_reg[i]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (s1_valid_reg)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end

        assign snap_data[i] = acc_next[i];
    end

    assign snap_valid = s1_valid_reg && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_start_reg <= 1'b1;
            start_reg    <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= pop;
            if (pop)
            begin
                s1_last_reg  <= in_item.last;
                s1_start_reg <= start_reg;
                start_reg    <= in_item.last;
            end
        end
    end

    a_snap_free: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |-> !bank_busy)
        else $error("snapshot while bank still draining");

endmodule

// File: hdl/mta_drain.sv
// ----------------------------------------------------------------------------
// mta_drain
// holds a finished tile and sends it out one element per word
// ----------------------------------------------------------------------------
module mta_drain
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      snap_valid,
    input  mta_pkg::acc_t             snap_data [mta_pkg::NUM_ACC],
    output logic                      busy,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mta_pkg::ROW_W-1:0] out_row,
    output logic [mta_pkg::COL_W-1:0] out_col,
    output mta_pkg::acc_t             out_value,
    output logic                      out_last
);

    localparam logic [mta_pkg::IDX_W-1:0] LAST_IDX = mta_pkg::IDX_W'(mta_pkg::NUM_ACC - 1);

    mta_pkg::acc_t              bank_reg [mta_pkg::NUM_ACC];
    logic                       busy_reg, busy_next;
    logic [mta_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mta_pkg::ROW_W-1:0]  row_reg;
    logic [mta_pkg::COL_W-1:0]  col_reg;
    mta_pkg::acc_t              value_reg;
    logic                       last_reg;
    logic                       advance;

    assign advance = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (snap_valid)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (advance)
        begin
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
            if (cnt_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid)
        begin
            for (int i = 0; i < mta_pkg::NUM_ACC; i++)
            begin
                bank_reg[i] <= snap_data[i];
            end
        end
        if (advance)
        begin
            value_reg <= bank_reg[cnt_reg];
            row_reg   <= mta_pkg::ROW_W'(cnt_reg >> mta_pkg::COL_W);
            col_reg   <= mta_pkg::COL_W'(cnt_reg);
            last_reg  <= (cnt_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |->
        (row_reg == mta_pkg::ROW_W'(mta_pkg::TILE_ROWS - 1)) &&
        (col_reg == mta_pkg::COL_W'(mta_pkg::TILE_COLS - 1)))
        else $error("tile end flagged away from final element");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |=> busy_reg && (cnt_reg == '0))
        else $error("drain did not restart on snapshot");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 4x8 tile accumulator
// ----------------------------------------------------------------------------
// steps are streamed in with random gaps while results are drained with
// random back-pressure. a tracker class keeps its own copy of the 32 sums,
// predicts every tile element at the step that closes the tile and checks
// each result word in order. a short directed part covers lane extremes,
// single-step tiles and accumulation over several steps;
// random tiles follow in phases with and without idling, one long receiver
// hold and a full drain between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import mta_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        acc_t             value;
        logic             last;
    } tile_elem_t;

    class tile_sum_tracker;
        acc_t       sums[NUM_ACC];
        bit         fresh_tile;
        tile_elem_t pending_elems[$];
        int         errors;

        function new();
            foreach (sums[i])
                sums[i] = '0;
            fresh_tile = 1'b1;
            errors     = 0;
        endfunction

        function int pending();
            return pending_elems.size();
        endfunction

        // one accepted step: update the sums, queue the tile on a last step
        function void note_step(input logic [WORD_W-1:0] a_col,
                                input logic [WORD_W-1:0] b_lo,
                                input logic [WORD_W-1:0] b_hi,
                                input logic              last_step);
            lane_t      a_lane;
            lane_t      b_lane[TILE_COLS];
            prod_t      prod;
            acc_t       prod_ext;
            tile_elem_t elem;
            for (int c = 0; c < TILE_COLS; c++)
                b_lane[c] = (c < 4) ? b_lo[LANE_W*c +: LANE_W] : b_hi[LANE_W*(c-4) +: LANE_W];
            for (int r = 0; r < TILE_ROWS; r++)
            begin
                a_lane = a_col[LANE_W*r +: LANE_W];
                for (int c = 0; c < TILE_COLS; c++)
                begin
                    prod     = a_lane * b_lane[c];
                    prod_ext = prod;
                    if (fresh_tile)
                        sums[r*TILE_COLS + c] = prod_ext;
                    else
                        sums[r*TILE_COLS + c] = sums[r*TILE_COLS + c] + prod_ext;
                end
            end
            fresh_tile = 1'b0;
            if (last_step)
            begin
                for (int r = 0; r < TILE_ROWS; r++)
                begin
                    for (int c = 0; c < TILE_COLS; c++)
                    begin
                        elem.row   = ROW_W'(r);
                        elem.col   = COL_W'(c);
                        elem.value = sums[r*TILE_COLS + c];
                        elem.last  = (r == TILE_ROWS-1) && (c == TILE_COLS-1);
                        pending_elems.push_back(elem);
                    end
                end
                fresh_tile = 1'b1;
            end
        endfunction

        function void check_element(input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col,
                                    input acc_t             value,
                                    input logic             last);
            tile_elem_t want;
            if (pending_elems.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: r%0d c%0d %0d last %0d",
                             row, col, value, last);
                return;
            end
            want = pending_elems.pop_front();
            if (want.row !== row || want.col !== col || want.value !== value ||
                want.last !== last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected r%0d c%0d %0d last %0d, got r%0d c%0d %0d last %0d",
                             want.row, want.col, want.value, want.last,
                             row, col, value, last);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // a_column, b_row_low, b_row_high
    logic         s_axis_tlast;   // last_step
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;   // tile_row, tile_col, dot_value, zero pad
    logic         m_axis_tlast;   // last_result

    bit              src_idle;
    bit              snk_idle;
    bit              hold_req;
    tile_sum_tracker tracker;

    matmul_tile_accumulator_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic [WORD_W-1:0] pack_lanes(input logic [15:0] l0, l1, l2, l3);
        return {l3, l2, l1, l0};
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return pack_lanes(rand_lane(), rand_lane(), rand_lane(), rand_lane());
    endfunction

    task automatic send_step(input logic [WORD_W-1:0] a_col, b_lo, b_hi, input logic last_step);
        int gap;
        gap = src_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b_hi, b_lo, a_col};
        s_axis_tlast  <= last_step;
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_step(a_col, b_lo, b_hi, last_step);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_tiles(input int n_steps);
        int sent;
        int depth;
        sent = 0;
        while (sent < n_steps)
        begin
            depth = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < depth; k++)
                send_step(rand_word(), rand_word(), rand_word(), k == depth - 1);
            sent += depth;
        end
    endtask

    // result words
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_element(m_axis_tdata[1:0], m_axis_tdata[4:2],
                                  m_axis_tdata[52:5], m_axis_tlast);
    end

    // receiver with random stalls and one long hold on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 12) : 0;
            if (hold_req)
            begin
                stall    = 400;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        hold_req      = 1'b0;
        tracker       = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single-step tiles at the lane extremes
        send_step(pack_lanes(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF),
                  pack_lanes(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001),
                  pack_lanes(16'h0100, 16'h7FFF, 16'h8000, 16'h0000), 1'b1);
        send_step({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 1'b1);
        send_step({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h8000}}, 1'b1);
        // accumulation over steps without last mark
        send_step('0, '0, '0, 1'b0);
        send_step({16{4'hA}}, {16{4'h5}}, {16{4'hA}}, 1'b0);
        send_step({16{4'h5}}, {16{4'hA}}, {16{4'h5}}, 1'b1);
        send_step({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 1'b0);
        send_step('0, {64{1'b1}}, '0, 1'b1);
        for (int k = 0; k < 4; k++)
            send_step(rand_word(), rand_word(), rand_word(), k == 3);
        drain_results();

        src_idle = 1'b1;
        snk_idle = 1'b1;
        random_tiles(52);
        drain_results();

        src_idle = 1'b0;
        snk_idle = 1'b0;
        random_tiles(52);
        drain_results();

        // long receiver hold while steps keep coming
        snk_idle = 1'b1;
        hold_req = 1'b1;
        random_tiles(52);
        drain_results();

        src_idle = 1'b1;
        snk_idle = 1'b0;
        random_tiles(52);
        drain_results();

        repeat (64) @(posedge clk);
        tracker.errors += tracker.pending();
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
